// ===== sv/set_assoc_lru_cache_tags_top_macros.svh =====
// Assertion macros for the cache tag store checker.
// Included by the checker file only.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_TOP_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_TOP_MACROS_SVH
// implication checked on every clock outside reset
`define SALC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");
// next-cycle implication checked on every clock outside reset
`define SALC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== sv/salc_pkg.sv =====
// Package of the cache tag store: sizes, controller codes and command struct.
// No dependencies.
`timescale 1ns / 1ps
package salc_pkg;
   localparam int ADDR_WIDTH_DEF   = 64;
   localparam int MAX_SET_BITS_DEF = 6;
   localparam int MAX_WAYS_DEF     = 8;

   localparam int CFG_SET_BITS    = 0;
   localparam int CFG_BLOCK_BITS  = 1;
   localparam int CFG_WAYS_IN_USE = 2;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_EXEC  = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   typedef struct packed {
      logic clear_wr;   // write a cleared set at clear index
      logic load_req;   // capture request payload
      logic rd_set;     // read the set into the datapath
      logic exec;       // compute and write back the set
      logic second;     // the access being executed is the first of two
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic two_access;
   } ctrl_sts_type;
endpackage

// ===== sv/set_assoc_lru_cache_tags_top.sv =====
// Top level of the set-associative LRU cache tag store.
// Request channel req_valid/req_ready carries action and address; each
// access returns one result on rsp_valid/rsp_ready, a modify gives two,
// rsp_last marks the final one. csr_write/csr_index/csr_data set set_bits,
// block_bits and ways_in_use (write only while idle).
// Steps: set read, then update and write back, then the result shows on
// rsp_valid. A request passes accept, read, update and show; a modify's
// second access loops through read, update and show again on the single
// set memory port.
// The result register holds while rsp_ready is low and no new request is
// taken until it is delivered.
// Reset: synchronous; a clearing pass writes one set a cycle until all
// 2**MAX_SET_BITS sets (64 by default) are cleared, req_ready stays low during it.
// Totals saturate at all ones.
`timescale 1ns / 1ps
module set_assoc_lru_cache_tags_top
   import salc_pkg::*;
#(
   parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
   parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = MAX_WAYS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [4:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [63:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic        rsp_miss,
   output logic        rsp_eviction,
   output logic [31:0] rsp_hit_total,
   output logic [31:0] rsp_miss_total,
   output logic [31:0] rsp_eviction_total,
   output logic        rsp_last
);
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   salc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   salc_datapath #(
      .ADDR_WIDTH(ADDR_WIDTH), .MAX_SET_BITS(MAX_SET_BITS), .MAX_WAYS(MAX_WAYS)
   ) u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .req_action,
      .req_address, .cmd, .sts, .rsp_hit, .rsp_miss, .rsp_eviction,
      .rsp_hit_total, .rsp_miss_total, .rsp_eviction_total, .rsp_last
   );
endmodule

// ===== sv/salc_ctrl.sv =====
// Controller state machine of the cache tag store.
// Depends on salc_pkg.
`timescale 1ns / 1ps
module salc_ctrl
   import salc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);
   logic [2:0] state_ff, state_in;
   logic       pend_ff, pend_in;   // a second access still to run

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_set = 1'b1;
            state_in   = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec   = 1'b1;
            cmd.second = ~pend_ff & sts.two_access;
            pend_in    = ~pend_ff & sts.two_access;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (pend_ff) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end
endmodule

// ===== sv/salc_datapath.sv =====
// Datapath of the cache tag store: set memory, LRU update and totals.
// Depends on salc_pkg.
`timescale 1ns / 1ps
module salc_datapath
   import salc_pkg::*;
#(
   parameter int ADDR_WIDTH   = ADDR_WIDTH_DEF,
   parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = MAX_WAYS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [4:0]            csr_data,
   input  logic                  req_action,
   input  logic [63:0]           req_address,
   input  ctrl_cmd_type          cmd,
   output ctrl_sts_type          sts,
   output logic                  rsp_hit,
   output logic                  rsp_miss,
   output logic                  rsp_eviction,
   output logic [31:0]           rsp_hit_total,
   output logic [31:0]           rsp_miss_total,
   output logic [31:0]           rsp_eviction_total,
   output logic                  rsp_last
);
   localparam int NUM_SETS = 1 << MAX_SET_BITS;
   localparam int SW       = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int AW       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WW       = $clog2(MAX_WAYS + 1);
   localparam logic [AW-1:0] AGE_LIMIT = AW'(MAX_WAYS - 1);

   typedef struct packed {
      logic          valid;
      logic [63:0]   tag;
      logic [AW-1:0] age;
   } line_type;
   typedef line_type [MAX_WAYS-1:0] set_type;

   set_type mem [NUM_SETS];
   set_type rd_ff;

   logic [2:0]  set_bits_ff;
   logic [4:0]  block_bits_ff;
   logic [3:0]  ways_ff;
   logic        action_ff;
   logic [SW-1:0] set_ff, clr_ff;
   logic [63:0] tag_ff;
   logic [31:0] hits_ff, misses_ff, evicts_ff;
   logic        hit_ff, evict_ff, last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= '0;
         block_bits_ff <= '0;
         ways_ff       <= 4'd1;
      end else if (csr_write) begin
         case (csr_index)
            2'(CFG_SET_BITS):    set_bits_ff   <= csr_data[2:0];
            2'(CFG_BLOCK_BITS):  block_bits_ff <= csr_data;
            2'(CFG_WAYS_IN_USE): ways_ff       <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // address split: one shifter for the set, one for the tag
   logic [63:0] a_mask, a_m;
   logic [3:0]  s_eff;
   logic [5:0]  sb;
   logic [63:0] set_full, tag_calc;
   always_comb begin
      a_mask   = (ADDR_WIDTH >= 64) ? '1 : ((64'd1 << ADDR_WIDTH) - 64'd1);
      a_m      = req_address & a_mask;
      s_eff    = (32'(set_bits_ff) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, set_bits_ff};
      sb       = 6'({2'b0, s_eff} + {1'b0, block_bits_ff});
      set_full = (a_m >> block_bits_ff) & ((64'd1 << s_eff) - 64'd1);
      tag_calc = ({2'b0, s_eff} + {1'b0, block_bits_ff} >= 7'd64) ? 64'd0 : (a_m >> sb);
   end

   logic [WW-1:0] ways;
   always_comb begin
      if (ways_ff == 4'd0) ways = WW'(1);
      else if (32'(ways_ff) > MAX_WAYS) ways = WW'(MAX_WAYS);
      else ways = WW'(ways_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= req_action;
         set_ff    <= SW'(set_full);
         tag_ff    <= tag_calc;
      end
   end

   // LRU update over the registered set
   set_type nxt;
   logic hit_c, evict_c, found, inv_found;
   logic [AW-1:0] mine, oldest;
   logic [AW-1:0] hit_w, inv_w, vic_w;
   always_comb begin
      nxt = rd_ff;
      hit_c = 1'b0; found = 1'b0; inv_found = 1'b0;
      hit_w = '0; inv_w = '0; vic_w = '0; oldest = '0; mine = '0;
      evict_c = 1'b0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (i < ways && !found && rd_ff[i].valid && rd_ff[i].tag == tag_ff) begin
            found = 1'b1; hit_w = AW'(i);
         end
         if (i < ways && !inv_found && !rd_ff[i].valid) begin
            inv_found = 1'b1; inv_w = AW'(i);
         end
         if (i < ways && rd_ff[i].age >= oldest) begin
            oldest = rd_ff[i].age; vic_w = AW'(i);
         end
      end
      mine  = rd_ff[hit_w].age;
      hit_c = found;
      if (found) begin
         for (int k = 0; k < MAX_WAYS; k++)
            if (k < ways && rd_ff[k].valid && rd_ff[k].age < mine)
               nxt[k].age = (rd_ff[k].age >= AGE_LIMIT) ? AGE_LIMIT : rd_ff[k].age + 1'b1;
         nxt[hit_w].age = '0;
      end else begin
         evict_c = ~inv_found;
         for (int k = 0; k < MAX_WAYS; k++)
            if (k < ways && (rd_ff[k].valid || !inv_found))
               nxt[k].age = (rd_ff[k].age >= AGE_LIMIT) ? AGE_LIMIT : rd_ff[k].age + 1'b1;
         if (inv_found) begin
            nxt[inv_w].age = '0; nxt[inv_w].valid = 1'b1; nxt[inv_w].tag = tag_ff;
         end else begin
            nxt[vic_w].age = '0; nxt[vic_w].tag = tag_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_wr) mem[clr_ff] <= '0;
      else if (cmd.exec) mem[set_ff] <= nxt;
      if (cmd.rd_set) rd_ff <= mem[set_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         hits_ff <= '0; misses_ff <= '0; evicts_ff <= '0;
      end else begin
         if (cmd.clear_wr) clr_ff <= clr_ff + 1'b1;
         if (cmd.exec) begin
            if (hit_c && hits_ff != '1) hits_ff <= hits_ff + 1'b1;
            if (!hit_c && misses_ff != '1) misses_ff <= misses_ff + 1'b1;
            if (evict_c && evicts_ff != '1) evicts_ff <= evicts_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         hit_ff   <= hit_c;
         evict_ff <= evict_c;
         last_ff  <= ~cmd.second;
      end
   end

   assign sts.clear_done = (clr_ff == SW'(NUM_SETS - 1)) || (MAX_SET_BITS == 0);
   assign sts.two_access = action_ff;
   assign rsp_hit = hit_ff;
   assign rsp_miss = ~hit_ff;
   assign rsp_eviction = evict_ff;
   assign rsp_hit_total = hits_ff;
   assign rsp_miss_total = misses_ff;
   assign rsp_eviction_total = evicts_ff;
   assign rsp_last = last_ff;
endmodule

// ===== sv/salc_checker.sv =====
// Port-level checker of the cache tag store, bound to the top level.
// Depends on set_assoc_lru_cache_tags_top_macros.svh.
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_tags_top_macros.svh"
module salc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic        rsp_miss,
   input logic        rsp_eviction
);
   `SALC_ASSERT_IMP(a_hit_xor_miss, clock, reset, rsp_valid, rsp_hit != rsp_miss)
   `SALC_ASSERT_IMP(a_evict_on_miss, clock, reset, rsp_valid && rsp_eviction, rsp_miss)
   `SALC_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `SALC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind set_assoc_lru_cache_tags_top salc_checker u_chk (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready, .rsp_hit, .rsp_miss,
   .rsp_eviction
);

// ===== dv/tb_set_assoc_lru_cache_tags_top.sv =====
// Self-checking testbench of the set-associative LRU cache tag store.
// Depends on salc_pkg and set_assoc_lru_cache_tags_top; holds its own LRU predictor.
`timescale 1ns / 1ps
module tb_set_assoc_lru_cache_tags_top
   import salc_pkg::*;
();

   localparam int SETS  = 1 << MAX_SET_BITS_DEF;
   localparam int WAYS  = MAX_WAYS_DEF;
   localparam int LINES = SETS * WAYS;
   localparam logic [2:0] AGE_TOP = 3'(WAYS - 1);

   typedef struct {
      bit          action;
      logic [63:0] address;
   } request_type;

   typedef struct {
      bit          hit;
      bit          miss;
      bit          eviction;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [31:0] eviction_total;
      bit          last;
   } lookup_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [4:0]  csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [63:0] req_address = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_hit, rsp_miss, rsp_eviction, rsp_last;
   logic [31:0] rsp_hit_total, rsp_miss_total, rsp_eviction_total;

   set_assoc_lru_cache_tags_top dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   bit          line_ok [LINES];
   logic [63:0] line_tag [LINES];
   logic [2:0]  line_age [LINES];
   logic [31:0] hits_pred = '0, misses_pred = '0, evicts_pred = '0;
   logic [2:0]  set_bits_reg = 3'd0;
   logic [4:0]  block_bits_reg = 5'd0;
   logic [3:0]  ways_reg = 4'd1;

   request_type pending_reqs[$];
   lookup_type  expected_lookups[$];
   int       errors = 0;
   bit       offering = 0;
   request_type cur_req;
   int       send_gap = 0;
   int       recv_gap = 0;
   int       hold_cycles = 0;
   bit       want_hold = 0;
   bit       bursty = 0;

   function automatic logic [2:0] age_up(logic [2:0] a);
      return (a == AGE_TOP) ? AGE_TOP : a + 3'd1;
   endfunction

   function automatic logic [31:0] count_up(logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
   endfunction

   function automatic void lru_lookup(logic [63:0] addr, bit is_last);
      int s, b, ways, base, i, k, victim, sb;
      logic [63:0] tg, set_no;
      logic [2:0] mine, oldest;
      bit h, ev;
      lookup_type r;
      s = (set_bits_reg > 3'(MAX_SET_BITS_DEF)) ? MAX_SET_BITS_DEF : int'(set_bits_reg);
      b = block_bits_reg;
      ways = ways_reg;
      if (ways == 0) ways = 1;
      if (ways > WAYS) ways = WAYS;
      sb = s + b;
      set_no = (addr >> b) & ((64'd1 << s) - 64'd1);
      tg = (sb >= 64) ? 64'd0 : addr >> sb;
      base = int'(set_no) * WAYS;
      h = 0;
      ev = 0;
      for (i = 0; i < ways; i++) begin
         if (line_ok[base+i] && line_tag[base+i] == tg) begin
            mine = line_age[base+i];
            for (k = 0; k < ways; k++)
               if (line_ok[base+k] && line_age[base+k] < mine)
                  line_age[base+k] = age_up(line_age[base+k]);
            line_age[base+i] = 3'd0;
            h = 1;
            break;
         end
      end
      if (h) begin
         hits_pred = count_up(hits_pred);
      end else begin
         misses_pred = count_up(misses_pred);
         victim = 0;
         oldest = 3'd0;
         for (i = 0; i < ways && line_ok[base+i]; i++) begin
            if (line_age[base+i] >= oldest) begin
               oldest = line_age[base+i];
               victim = i;
            end
         end
         if (i != ways) begin
            for (k = 0; k < ways; k++)
               if (line_ok[base+k]) line_age[base+k] = age_up(line_age[base+k]);
            line_age[base+i] = 3'd0;
            line_ok[base+i] = 1;
            line_tag[base+i] = tg;
         end else begin
            ev = 1;
            evicts_pred = count_up(evicts_pred);
            for (k = 0; k < ways; k++) line_age[base+k] = age_up(line_age[base+k]);
            line_age[base+victim] = 3'd0;
            line_tag[base+victim] = tg;
         end
      end
      r.hit = h;
      r.miss = !h;
      r.eviction = ev;
      r.hit_total = hits_pred;
      r.miss_total = misses_pred;
      r.eviction_total = evicts_pred;
      r.last = is_last;
      expected_lookups.push_back(r);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int draw_gap();
      return bursty ? 0 : $urandom_range(0, 18);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            void'(pending_reqs.pop_front());
            lru_lookup(cur_req.address, !cur_req.action);
            if (cur_req.action) lru_lookup(cur_req.address, 1);
            offering = 0;
            if ($urandom_range(0, 15) == 0) bursty = !bursty;
            send_gap = draw_gap();
         end
         if (!offering) begin
            if (send_gap > 0) send_gap--;
            else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs[0];
               offering = 1;
            end
         end
         req_valid <= offering;
         req_action <= cur_req.action;
         req_address <= cur_req.address;
      end
   end

   // monitor
   always @(posedge clock) begin
      lookup_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_lookups.size() == 0) begin
               report_mismatch("unexpected result", 64'd1, 64'd0);
            end else begin
               e = expected_lookups.pop_front();
               if (rsp_hit !== e.hit) report_mismatch("hit", rsp_hit, e.hit);
               if (rsp_miss !== e.miss) report_mismatch("miss", rsp_miss, e.miss);
               if (rsp_eviction !== e.eviction)
                  report_mismatch("eviction", rsp_eviction, e.eviction);
               if (rsp_hit_total !== e.hit_total)
                  report_mismatch("hit_total", rsp_hit_total, e.hit_total);
               if (rsp_miss_total !== e.miss_total)
                  report_mismatch("miss_total", rsp_miss_total, e.miss_total);
               if (rsp_eviction_total !== e.eviction_total)
                  report_mismatch("eviction_total", rsp_eviction_total, e.eviction_total);
               if (rsp_last !== e.last) report_mismatch("last", rsp_last, e.last);
            end
            recv_gap = draw_gap();
         end
         if (want_hold) begin
            hold_cycles = 300;
            want_hold = 0;
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || offering || expected_lookups.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_regs(logic [2:0] sets, logic [4:0] blk, logic [3:0] ways);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= 2'(CFG_SET_BITS);
      csr_data <= 5'(sets);
      @(posedge clock);
      csr_index <= 2'(CFG_BLOCK_BITS);
      csr_data <= blk;
      @(posedge clock);
      csr_index <= 2'(CFG_WAYS_IN_USE);
      csr_data <= 5'(ways);
      @(posedge clock);
      csr_write <= 1'b0;
      set_bits_reg = sets;
      block_bits_reg = blk;
      ways_reg = ways;
   endtask

   task automatic push_req(bit act, logic [63:0] addr);
      request_type r;
      r.action = act;
      r.address = addr;
      pending_reqs.push_back(r);
   endtask

   // mostly reuse a few tags per set so hits and evictions are common
   function automatic logic [63:0] pick_address();
      int s, b;
      logic [63:0] tg, set_no, offs;
      if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
      s = (set_bits_reg > 3'd6) ? 6 : int'(set_bits_reg);
      b = block_bits_reg;
      tg = $urandom_range(0, 11);
      if ($urandom_range(0, 7) == 0) tg = tg | {$urandom, $urandom} & ~64'hFF;
      set_no = $urandom_range(0, 3);
      offs = {$urandom, $urandom} & ((64'd1 << b) - 64'd1);
      return (tg << (s + b)) | (set_no << b) | offs;
   endfunction

   logic [2:0] phase_sets [8] = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd6, 3'd3, 3'd0, 3'd1};
   logic [4:0] phase_blk  [8] = '{5'd2, 5'd0, 5'd31, 5'd4, 5'd16, 5'd6, 5'd1, 5'd3};
   logic [3:0] phase_ways [8] = '{4'd4, 4'd1, 4'd0, 4'd15, 4'd8, 4'd2, 4'd3, 4'd8};

   initial begin
      int p, n;
      foreach (line_ok[i]) begin
         line_ok[i] = 0;
         line_tag[i] = '0;
         line_age[i] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: one way, no index, no offset
      push_req(0, 64'd0);
      push_req(0, 64'd0);
      push_req(0, 64'hFFFF_FFFF_FFFF_FFFF);
      push_req(1, 64'd5);
      push_req(1, 64'd0);
      wait_idle();
      // oversized set bits, widest offset, zero ways
      write_regs(3'd7, 5'd31, 4'd0);
      push_req(0, 64'hFFFF_FFFF_FFFF_FFFF);
      push_req(0, 64'hFFFF_FFFF_FFFF_FFFF);
      push_req(1, 64'h0000_0040_0000_0000);
      push_req(0, 64'd0);
      wait_idle();
      // fill one set of eight, shrink the ways, then widen again so ages saturate
      write_regs(3'd0, 5'd0, 4'd8);
      for (int t = 1; t <= 8; t++) push_req(0, 64'(t));
      wait_idle();
      write_regs(3'd0, 5'd0, 4'd2);
      push_req(0, 64'd20);
      push_req(1, 64'd21);
      wait_idle();
      write_regs(3'd0, 5'd0, 4'd9);
      push_req(0, 64'd3);
      push_req(0, 64'd30);
      push_req(0, 64'd31);
      wait_idle();

      for (p = 0; p < 8; p++) begin
         write_regs(phase_sets[p], phase_blk[p], phase_ways[p]);
         if (p == 3) begin
            @(negedge clock);
            want_hold = 1;
         end
         for (n = 0; n < 62; n++) begin
            push_req($urandom_range(0, 2) == 0, pick_address());
            // pause until drained once, midway through phase 5
            if (n == 30 && p == 5) wait_idle();
         end
         wait_idle();
      end

      repeat (30) @(posedge clock);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("simulation failed");
      $finish;
   end
endmodule
